[hdl/bitmap_first_fit_allocator_core_macros.svh]
// Assertion macros for the bitmap first-fit allocator.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define BMFFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define BMFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMFFA_ASSERT_SAME(lbl, ante, cons, msg)
`define BMFFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/bmffa_pkg.sv]
// Shared types and constants of the bitmap first-fit allocator.
// No dependencies; the files that use it refer to it by scoped names.
package bmffa_pkg;

    // Field widths of the request and response transactions.
    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 4;
    localparam int START_W  = 3;
    localparam int OFFSET_W = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int MAP_W    = 8;

    // Store depth: default and the largest supported value.
    localparam int STORE_WORDS_DEF = 8;
    localparam int STORE_WORDS_MAX = 64;

    // Width of word positions and range bounds: holds the largest start plus size.
    localparam int RANGE_W = $clog2(STORE_WORDS_MAX + (2 ** SIZE_W));

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_SPACE     = 3'd1,
        ST_FRAGMENTED   = 3'd2,
        ST_BAD_SIZE     = 3'd3,
        ST_INVALID      = 3'd4,
        ST_FREE_IGNORED = 3'd5
    } status_t;

    // Scan token passed from cell to cell during an allocation search.
    // The free count saturates, which is enough to compare against any size.
    typedef struct packed {
        logic              live;
        logic [SIZE_W-1:0] run;
        logic [SIZE_W-1:0] free_cnt;
    } scan_tok_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic               set_run;
        logic               clr_run;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        logic               wr_mark;
        logic [RANGE_W-1:0] pos;
        logic [SIZE_W-1:0]  size;
    } cell_cmd_t;

endpackage

[hdl/bmffa_req_if.sv]
// Request channel of the bitmap first-fit allocator.
// Depends on bmffa_pkg for field widths.
interface bmffa_req_if;

    logic                                valid;
    logic                                ready;
    logic [bmffa_pkg::ACTION_W-1:0]      action;
    logic [bmffa_pkg::SIZE_W-1:0]        block_size;
    logic [bmffa_pkg::START_W-1:0]       block_start;
    logic [bmffa_pkg::OFFSET_W-1:0]      word_offset;
    logic signed [bmffa_pkg::DATA_W-1:0] write_value;

    modport source (
        output valid, action, block_size, block_start, word_offset, write_value,
        input  ready
    );

    modport sink (
        input  valid, action, block_size, block_start, word_offset, write_value,
        output ready
    );

endinterface

[hdl/bmffa_rsp_if.sv]
// Response channel of the bitmap first-fit allocator.
// Depends on bmffa_pkg for field widths.
interface bmffa_rsp_if;

    logic                                valid;
    logic                                ready;
    logic [bmffa_pkg::STATUS_W-1:0]      status;
    logic [bmffa_pkg::START_W-1:0]       alloc_start;
    logic signed [bmffa_pkg::DATA_W-1:0] read_data;
    logic [bmffa_pkg::MAP_W-1:0]         occupied_map;

    modport source (
        output valid, status, alloc_start, read_data, occupied_map,
        input  ready
    );

    modport sink (
        input  valid, status, alloc_start, read_data, occupied_map,
        output ready
    );

endinterface

[hdl/bmffa_ram.sv]
// Generic single-port RAM with a registered read.
// No dependencies.
module bmffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // At most one write and one read per cycle, at the shared address; read data appears the cycle after.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/bmffa_cell.sv]
// One word slot of the allocator: occupancy bit, written flag and scan stage.
// Depends on bmffa_pkg for the command and scan token types.
module bmffa_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bmffa_pkg::cell_cmd_t  cmd,
    input  bmffa_pkg::scan_tok_t  tok_in,
    output bmffa_pkg::scan_tok_t  tok_out,
    output logic                  hit,
    output logic                  occ,
    output logic                  wvalid
);

    localparam int RW = bmffa_pkg::RANGE_W;
    localparam logic [RW-1:0] MY_IDX = RW'(IDX);

    logic                 occ_reg;
    logic                 occ_next;
    logic                 wvalid_reg;
    logic                 wvalid_next;
    logic                 hit_reg;
    logic                 hit_next;
    bmffa_pkg::scan_tok_t tok_reg;
    bmffa_pkg::scan_tok_t tok_next;
    logic                 in_range;
    logic [bmffa_pkg::SIZE_W-1:0] run_inc;

    assign in_range = (MY_IDX >= cmd.lo) && (MY_IDX < cmd.hi);
    assign run_inc  = tok_in.run + 1'b1;

    // Scan stage: extend or break the free run and count free words.
    always_comb
    begin
        hit_next      = tok_in.live && !occ_reg && (run_inc == cmd.size);
        tok_next.live = tok_in.live && !hit_next;
        tok_next.run  = occ_reg ? '0 : run_inc;
        if (occ_reg || (tok_in.free_cnt == '1))
        begin
            tok_next.free_cnt = tok_in.free_cnt;
        end
        else
        begin
            tok_next.free_cnt = tok_in.free_cnt + 1'b1;
        end
    end

    // Occupancy and written-flag updates from the broadcast command.
    always_comb
    begin
        priority if (cmd.set_run && in_range)
        begin
            occ_next = 1'b1;
        end
        else if (cmd.clr_run && in_range)
        begin
            occ_next = 1'b0;
        end
        else
        begin
            occ_next = occ_reg;
        end
        wvalid_next = wvalid_reg || (cmd.wr_mark && (cmd.pos == MY_IDX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= 1'b0;
            wvalid_reg <= 1'b0;
            hit_reg    <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            occ_reg    <= occ_next;
            wvalid_reg <= wvalid_next;
            hit_reg    <= hit_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign hit     = hit_reg;
    assign occ     = occ_reg;
    assign wvalid  = wvalid_reg;

endmodule

[hdl/bitmap_first_fit_allocator_core.sv]
// Top level of the bitmap first-fit allocator: controller, cell row and word RAM.
// Depends on bmffa_pkg, bmffa_req_if, bmffa_rsp_if, bmffa_cell, bmffa_ram and the macro header.
//
//   Channel | Direction | Handshake   | Carries
//   --------+-----------+-------------+-------------------------------------------------
//   req     | in        | valid/ready | action, block_size, block_start, word_offset, value
//   rsp     | out       | valid/ready | status, alloc_start, read_data, occupied_map
//
// One request is in flight at a time; req.ready is high only while the controller is idle.
// Free, write, read and a bad-size allocate go straight from idle to S_OUT, and req.ready
// returns in the same cycle as rsp.valid rises.
// An allocate passes a scan token along the cell row, one cell per cycle: a grant goes
// through S_SCAN, S_MARK and S_OUT, a failed search from S_SCAN straight to S_OUT.
// A stalled response holds the controller until rsp takes the transaction.
// Reset empties the bitmap and marks every word unwritten, so unwritten words read as zero.
`include "bitmap_first_fit_allocator_core_macros.svh"

module bitmap_first_fit_allocator_core #(
    parameter int STORE_WORDS = bmffa_pkg::STORE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmffa_req_if.sink   req,
    bmffa_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(STORE_WORDS);
    localparam int PAD_W = 2 ** IDX_W;
    localparam int RW    = bmffa_pkg::RANGE_W;
    localparam logic [RW-1:0]    WORDS_R  = RW'(STORE_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_WORDS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_OUT
    } state_t;

    state_t                         state_reg;
    logic [bmffa_pkg::SIZE_W-1:0]   size_reg;
    logic [IDX_W-1:0]               pos_reg;
    logic                           rd_ok_reg;
    logic [RW-1:0]                  start_reg;
    logic [IDX_W-1:0]               scan_idx_reg;
    bmffa_pkg::status_t             status_reg;
    logic                           rsp_valid_reg;
    logic [bmffa_pkg::STATUS_W-1:0] rsp_status_reg;
    logic [bmffa_pkg::START_W-1:0]  rsp_start_reg;
    logic [bmffa_pkg::DATA_W-1:0]   rsp_data_reg;
    logic [bmffa_pkg::MAP_W-1:0]    rsp_map_reg;

    bmffa_pkg::cell_cmd_t           cmd;
    bmffa_pkg::scan_tok_t           tok_chain [STORE_WORDS+1];
    logic [STORE_WORDS-1:0]         hit_vec;
    logic [STORE_WORDS-1:0]         live_vec;
    logic [STORE_WORDS-1:0]         occ_vec;
    logic [STORE_WORDS-1:0]         wvalid_vec;
    logic [PAD_W-1:0]               occ_pad;
    logic [PAD_W-1:0]               wvalid_pad;
    logic [bmffa_pkg::MAP_W-1:0]    map_w;

    logic                           req_fire;
    bmffa_pkg::action_t             req_action;
    logic [RW-1:0]                  size_r;
    logic [RW-1:0]                  start_r;
    logic [RW-1:0]                  free_hi;
    logic [RW-1:0]                  pos_r;
    logic                           pos_ok;
    logic                           size_bad;
    logic                           free_ignored;
    logic                           any_hit;
    logic [RW-1:0]                  found_start;
    logic                           ram_we;
    logic                           ram_re;
    logic [bmffa_pkg::DATA_W-1:0]   ram_rdata;
    logic [bmffa_pkg::DATA_W-1:0]   read_result;

    // Request decode.
    assign req.ready    = (state_reg == S_IDLE);
    assign req_fire     = req.valid && req.ready;
    assign req_action   = bmffa_pkg::action_t'(req.action);
    assign size_r       = RW'(req.block_size);
    assign start_r      = RW'(req.block_start);
    assign free_hi      = start_r + size_r;
    assign pos_r        = start_r + RW'(req.word_offset);
    assign occ_pad      = PAD_W'(occ_vec);
    assign wvalid_pad   = PAD_W'(wvalid_vec);
    assign pos_ok       = (pos_r < WORDS_R) && occ_pad[pos_r[IDX_W-1:0]];
    assign size_bad     = (req.block_size == '0) || (size_r > WORDS_R);
    assign free_ignored = free_hi > WORDS_R;

    // Scan results: a hit ends the run at the cell that holds the token.
    assign any_hit     = |hit_vec;
    assign found_start = RW'(scan_idx_reg) - RW'(size_reg) + RW'(1);

    // Command broadcast to the cells.
    always_comb
    begin
        cmd      = '0;
        cmd.size = (state_reg == S_IDLE) ? req.block_size : size_reg;
        if (req_fire && (req_action == bmffa_pkg::ACT_FREE) && !free_ignored)
        begin
            cmd.clr_run = 1'b1;
            cmd.lo      = start_r;
            cmd.hi      = free_hi;
        end
        if (req_fire && (req_action == bmffa_pkg::ACT_WRITE) && pos_ok)
        begin
            cmd.wr_mark = 1'b1;
            cmd.pos     = pos_r;
        end
        if (state_reg == S_MARK)
        begin
            cmd.set_run = 1'b1;
            cmd.lo      = start_reg;
            cmd.hi      = start_reg + RW'(size_reg);
        end
    end

    // A fresh token enters the first cell when an allocate with a valid size is accepted.
    always_comb
    begin
        tok_chain[0]      = '0;
        tok_chain[0].live = req_fire && (req_action == bmffa_pkg::ACT_ALLOC) && !size_bad;
    end

    // Row of cells, one per store word.
    for (genvar i = 0; i < STORE_WORDS; i++)
    begin : g_cell
        bmffa_cell #(
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .hit     (hit_vec[i]),
            .occ     (occ_vec[i]),
            .wvalid  (wvalid_vec[i])
        );
        assign live_vec[i] = tok_chain[i+1].live;
    end

    // Low byte of the bitmap; missing bits read as zero on small stores.
    for (genvar b = 0; b < bmffa_pkg::MAP_W; b++)
    begin : g_map
        if (b < STORE_WORDS)
        begin : g_bit
            assign map_w[b] = occ_vec[b];
        end
        else
        begin : g_zero
            assign map_w[b] = 1'b0;
        end
    end

    // Word store; a word never written reads as zero through its written flag.
    assign ram_we = req_fire && (req_action == bmffa_pkg::ACT_WRITE) && pos_ok;
    assign ram_re = req_fire && (req_action == bmffa_pkg::ACT_READ) && pos_ok;

    bmffa_ram #(
        .WIDTH (bmffa_pkg::DATA_W),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (pos_r[IDX_W-1:0]),
        .wdata (req.write_value),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (!rd_ok_reg)
        begin
            read_result = '1;
        end
        else if (wvalid_pad[pos_reg])
        begin
            read_result = ram_rdata;
        end
        else
        begin
            read_result = '0;
        end
    end

    // Controller state and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_reg       <= '0;
            pos_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            start_reg      <= '0;
            scan_idx_reg   <= '0;
            status_reg     <= bmffa_pkg::ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= '0;
            rsp_start_reg  <= '0;
            rsp_data_reg   <= '0;
            rsp_map_reg    <= '0;
        end
        else
        begin
            // Outside S_OUT a taken response simply empties the register.
            if (rsp_valid_reg && rsp.ready && (state_reg != S_OUT))
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        size_reg     <= req.block_size;
                        pos_reg      <= pos_r[IDX_W-1:0];
                        rd_ok_reg    <= (req_action == bmffa_pkg::ACT_READ) && pos_ok;
                        start_reg    <= '0;
                        scan_idx_reg <= '0;
                        unique case (req_action)
                            bmffa_pkg::ACT_ALLOC:
                            begin
                                if (size_bad)
                                begin
                                    status_reg <= bmffa_pkg::ST_BAD_SIZE;
                                    state_reg  <= S_OUT;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN;
                                end
                            end
                            bmffa_pkg::ACT_FREE:
                            begin
                                status_reg <= free_ignored ? bmffa_pkg::ST_FREE_IGNORED
                                                           : bmffa_pkg::ST_OK;
                                state_reg  <= S_OUT;
                            end
                            bmffa_pkg::ACT_WRITE,
                            bmffa_pkg::ACT_READ:
                            begin
                                status_reg <= pos_ok ? bmffa_pkg::ST_OK
                                                     : bmffa_pkg::ST_INVALID;
                                state_reg  <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    priority if (any_hit)
                    begin
                        start_reg  <= found_start;
                        status_reg <= bmffa_pkg::ST_OK;
                        state_reg  <= S_MARK;
                    end
                    else if (scan_idx_reg == LAST_IDX)
                    begin
                        status_reg <= (tok_chain[STORE_WORDS].free_cnt >= size_reg)
                                      ? bmffa_pkg::ST_FRAGMENTED : bmffa_pkg::ST_NO_SPACE;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_MARK:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_start_reg  <= start_reg[bmffa_pkg::START_W-1:0];
                        rsp_data_reg   <= read_result;
                        rsp_map_reg    <= map_w;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.alloc_start  = rsp_start_reg;
    assign rsp.read_data    = rsp_data_reg;
    assign rsp.occupied_map = rsp_map_reg;

    // At most one scan token travels the row.
    `BMFFA_ASSERT_SAME(a_single_token, 1'b1, $onehot0(live_vec), "more than one scan token live")
    // The scan index follows the cell that holds the token.
    `BMFFA_ASSERT_SAME(a_scan_track, state_reg == S_SCAN, live_vec[scan_idx_reg] || hit_vec[scan_idx_reg], "scan index lost the token")
    // Marking a grant sets exactly size words that were free.
    `BMFFA_ASSERT_NEXT(a_mark_count, state_reg == S_MARK, $countones(occ_vec) == $past($countones(occ_vec)) + int'(size_reg), "grant did not mark a free run")
    // A word is written only while it is allocated.
    `BMFFA_ASSERT_SAME(a_write_owned, cmd.wr_mark, occ_pad[cmd.pos[IDX_W-1:0]], "write to an unallocated word")

endmodule
